### hw/rtl/prsw_pkg.sv
// ----------------------------------------------------------------------------
// prsw_pkg
// Shared types and constants for the planar rectangle span writer.
// ----------------------------------------------------------------------------
package prsw_pkg;

   // parameter defaults
   localparam int DEF_ADDR_BITS  = 16;
   localparam int DEF_COORD_BITS = 10;
   localparam int DEF_MAX_STRIDE = 128;

   // fixed field widths
   localparam int FIELD_COORD_BITS = 10;
   localparam int FIELD_ADDR_BITS  = 16;
   localparam int STRIDE_BITS      = 8;
   localparam int BASE_BITS        = 16;
   localparam int MASK_BITS        = 8;
   localparam int COLOR_BITS       = 4;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_LINE_STRIDE = 1'b0;
   localparam logic REG_FRAME_BASE  = 1'b1;

   localparam logic [STRIDE_BITS-1:0] RESET_LINE_STRIDE = 8'd80;
   localparam logic [BASE_BITS-1:0]   RESET_FRAME_BASE  = 16'h0000;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic [MASK_BITS-1:0]  FULL_MASK    = 8'hff;
   localparam logic [COLOR_BITS-1:0] INVERT_COLOR = 4'hf;

   typedef struct packed {
      logic                        req_type;
      logic [FIELD_COORD_BITS-1:0] x_left;
      logic [FIELD_COORD_BITS-1:0] y_top;
      logic [FIELD_COORD_BITS-1:0] x_right;
      logic [FIELD_COORD_BITS-1:0] y_bottom;
      logic [COLOR_BITS-1:0]       fill_color;
      logic                        invert;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_ADDR_BITS-1:0] byte_address;
      logic [MASK_BITS-1:0]       bit_mask;
      logic [COLOR_BITS-1:0]      plane_color;
      logic                       xor_op;
      logic                       last;
   } rsp_word_type;

endpackage

### hw/rtl/planar_rect_span_writer.sv
// ----------------------------------------------------------------------------
// planar_rect_span_writer
// Byte write generator for filling or inverting a rectangle on a packed
// 1-bit-per-plane framebuffer, one write per step word during a rectangle.
//
//   port group   direction   carries
//   req_*        in          start word (corners, color, invert) or step word
//   rsp_*        out         byte address, bit mask, plane color, xor, last
//   csr_*        in/out      line stride at 0x0, frame base at 0x4
//
// one word per cycle unless rsp_stall holds a full output register: input
// register, setup or walk logic, output register.
// the stride multiply in the start setup sets the path between the registers.
// reset is synchronous and clears the walker and both register valids.
// rsp_stall holds the output word and, once the input register is also
// full, raises req_stall in the same cycle.
// ----------------------------------------------------------------------------
module planar_rect_span_writer
   import prsw_pkg::*;
#(
   parameter int ADDR_BITS  = DEF_ADDR_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int MAX_STRIDE = DEF_MAX_STRIDE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic                   in_valid_ff, in_valid_in;
   req_word_type           in_data_ff, in_data_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_word_type           out_data_ff, out_data_in;
   logic                   req_take;
   logic                   advance;
   logic                   res_valid;
   rsp_word_type           res_word;
   logic [STRIDE_BITS-1:0] line_stride;
   logic [BASE_BITS-1:0]   frame_base;

   prsw_csr #(
      .MAX_STRIDE (MAX_STRIDE)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .line_stride (line_stride),
      .frame_base  (frame_base)
   );

   prsw_span_walker #(
      .ADDR_BITS  (ADDR_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_word    (in_data_ff),
      .line_stride (line_stride),
      .frame_base  (frame_base),
      .res_valid   (res_valid),
      .res_word    (res_word)
   );

   // the held word moves on whenever the output register has room
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_data_in = res_word;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // no result survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side only stalls behind a full, stalled output register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // a start word never produces a write
   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_data_ff.req_type == REQ_START)) |=> !rsp_valid)
      else $error("start word produced a result");

endmodule

### hw/rtl/prsw_csr.sv
// ----------------------------------------------------------------------------
// prsw_csr
// Configuration registers: line stride (saturated) and frame base address.
// ----------------------------------------------------------------------------
module prsw_csr
   import prsw_pkg::*;
#(
   parameter int MAX_STRIDE = DEF_MAX_STRIDE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [STRIDE_BITS-1:0]   line_stride,
   output logic [BASE_BITS-1:0]     frame_base
);

   localparam int StrideCap = (MAX_STRIDE > 255) ? 255 : MAX_STRIDE;

   logic [STRIDE_BITS-1:0] stride_ff, stride_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic                   wr_en;
   logic                   reg_sel;
   logic [STRIDE_BITS-1:0] wr_stride;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];
   assign wr_stride  = csr_pwdata[STRIDE_BITS-1:0];

   always_comb begin
      stride_in = stride_ff;
      base_in   = base_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_LINE_STRIDE: begin
               stride_in = (wr_stride > STRIDE_BITS'(StrideCap)) ?
                           STRIDE_BITS'(StrideCap) : wr_stride;
            end
            REG_FRAME_BASE: begin
               base_in = csr_pwdata[BASE_BITS-1:0];
            end
            default: begin
               stride_in = stride_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= RESET_LINE_STRIDE;
         base_ff   <= RESET_FRAME_BASE;
      end else begin
         stride_ff <= stride_in;
         base_ff   <= base_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LINE_STRIDE: csr_prdata = CSR_DATA_BITS'(stride_ff);
         REG_FRAME_BASE:  csr_prdata = CSR_DATA_BITS'(base_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign line_stride = stride_ff;
   assign frame_base  = base_ff;

endmodule

### hw/rtl/prsw_span_walker.sv
// ----------------------------------------------------------------------------
// prsw_span_walker
// Rectangle setup and span walk: splits each row into left, middle and right
// byte parts and emits one byte write per step word while a rectangle is open.
// ----------------------------------------------------------------------------
module prsw_span_walker
   import prsw_pkg::*;
#(
   parameter int ADDR_BITS  = DEF_ADDR_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  req_word_type           req_word,
   input  logic [STRIDE_BITS-1:0] line_stride,
   input  logic [BASE_BITS-1:0]   frame_base,
   output logic                   res_valid,
   output rsp_word_type           res_word
);

   localparam int MID_BITS  = COORD_BITS - 2;
   localparam int WIDE_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = STRIDE_BITS + COORD_BITS;

   typedef enum logic [1:0] {
      PH_LEFT,
      PH_MIDDLE,
      PH_RIGHT
   } phase_type;

   // state
   logic                  busy_ff, busy_in;
   phase_type             phase_ff, phase_in;
   logic [ADDR_BITS-1:0]  row_addr_ff, row_addr_in;
   logic [ADDR_BITS-1:0]  wr_addr_ff, wr_addr_in;
   logic [COORD_BITS-1:0] rows_rem_ff, rows_rem_in;
   logic [MID_BITS-1:0]   mid_rem_ff, mid_rem_in;
   logic [MID_BITS-1:0]   mid_cnt_ff, mid_cnt_in;
   logic [MASK_BITS-1:0]  left_mask_ff, left_mask_in;
   logic [MASK_BITS-1:0]  right_mask_ff, right_mask_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  invert_ff, invert_in;

   // start decode
   logic [COORD_BITS-1:0] x1, y1, x2, y2;
   logic                  corners_ok;
   logic [WIDE_BITS-1:0]  width;
   logic [2:0]            left_len;
   logic [2:0]            right_len;
   logic                  left_fits;
   logic [WIDE_BITS-1:0]  span_len;
   logic [MID_BITS-1:0]   start_mid;
   logic [2:0]            trim_sh;
   logic [MASK_BITS-1:0]  start_left_mask;
   logic [MASK_BITS-1:0]  start_right_mask;
   logic [PROD_BITS-1:0]  row_offset;
   logic [ADDR_BITS-1:0]  start_addr;
   phase_type             start_phase;

   // step helpers
   logic [ADDR_BITS-1:0]  next_row_addr;
   phase_type             row_first_phase;
   logic                  row_end;
   logic                  final_write;
   logic [MASK_BITS-1:0]  step_mask;

   assign x1 = COORD_BITS'(req_word.x_left);
   assign y1 = COORD_BITS'(req_word.y_top);
   assign x2 = COORD_BITS'(req_word.x_right);
   assign y2 = COORD_BITS'(req_word.y_bottom);

   assign corners_ok = (x1 <= x2) && (y1 <= y2);
   assign width      = WIDE_BITS'(x2) - WIDE_BITS'(x1) + WIDE_BITS'(1);

   // pixels up to the next byte boundary, zero when already aligned
   assign left_len  = 3'd0 - x1[2:0];
   assign left_fits = WIDE_BITS'(left_len) >= width;
   assign right_len = left_fits ? 3'd0 : (x2[2:0] + 3'd1);
   assign span_len  = width - WIDE_BITS'(left_len) - WIDE_BITS'(right_len);
   assign start_mid = left_fits ? '0 : span_len[WIDE_BITS-1:3];

   // narrow rectangle inside one byte: drop pixels right of x_right
   assign trim_sh = left_len - width[2:0];
   always_comb begin
      start_left_mask = ~(FULL_MASK << left_len);
      if (WIDE_BITS'(left_len) > width) begin
         start_left_mask = start_left_mask & (FULL_MASK << trim_sh);
      end
   end
   assign start_right_mask = ~(FULL_MASK >> right_len);

   assign row_offset = line_stride * y1;
   assign start_addr = ADDR_BITS'(frame_base) + ADDR_BITS'(row_offset) +
                       ADDR_BITS'(x1[COORD_BITS-1:3]);

   assign start_phase = (start_left_mask != '0) ? PH_LEFT :
                        (start_mid != '0)       ? PH_MIDDLE : PH_RIGHT;

   assign next_row_addr   = row_addr_ff + ADDR_BITS'(line_stride);
   assign row_first_phase = (left_mask_ff != '0) ? PH_LEFT :
                            (mid_cnt_ff != '0)   ? PH_MIDDLE : PH_RIGHT;
   assign final_write     = row_end && (rows_rem_ff == '0);

   always_comb begin
      busy_in       = busy_ff;
      phase_in      = phase_ff;
      row_addr_in   = row_addr_ff;
      wr_addr_in    = wr_addr_ff;
      rows_rem_in   = rows_rem_ff;
      mid_rem_in    = mid_rem_ff;
      mid_cnt_in    = mid_cnt_ff;
      left_mask_in  = left_mask_ff;
      right_mask_in = right_mask_ff;
      color_in      = color_ff;
      invert_in     = invert_ff;
      row_end       = 1'b0;
      step_mask     = '0;
      res_valid     = 1'b0;

      if (advance) begin
         if (req_word.req_type == REQ_START) begin
            busy_in       = corners_ok;
            phase_in      = start_phase;
            row_addr_in   = start_addr;
            wr_addr_in    = start_addr;
            rows_rem_in   = y2 - y1;
            mid_rem_in    = start_mid;
            mid_cnt_in    = start_mid;
            left_mask_in  = start_left_mask;
            right_mask_in = start_right_mask;
            invert_in     = req_word.invert;
            color_in      = req_word.invert ? INVERT_COLOR : req_word.fill_color;
         end else if (busy_ff) begin
            res_valid = 1'b1;
            case (phase_ff)
               PH_LEFT: begin
                  step_mask  = left_mask_ff;
                  wr_addr_in = wr_addr_ff + 1'b1;
                  if (mid_cnt_ff != '0) begin
                     phase_in   = PH_MIDDLE;
                     mid_rem_in = mid_cnt_ff;
                  end else if (right_mask_ff != '0) begin
                     phase_in = PH_RIGHT;
                  end else begin
                     row_end = 1'b1;
                  end
               end
               PH_MIDDLE: begin
                  step_mask  = FULL_MASK;
                  wr_addr_in = wr_addr_ff + 1'b1;
                  mid_rem_in = mid_rem_ff - 1'b1;
                  if (mid_rem_ff != MID_BITS'(1)) begin
                     phase_in = PH_MIDDLE;
                  end else if (right_mask_ff != '0) begin
                     phase_in = PH_RIGHT;
                  end else begin
                     row_end = 1'b1;
                  end
               end
               PH_RIGHT: begin
                  step_mask = right_mask_ff;
                  row_end   = 1'b1;
               end
               default: begin
                  step_mask = '0;
                  row_end   = 1'b1;
               end
            endcase

            if (row_end) begin
               if (rows_rem_ff == '0) begin
                  busy_in = 1'b0;
               end else begin
                  rows_rem_in = rows_rem_ff - 1'b1;
                  row_addr_in = next_row_addr;
                  wr_addr_in  = next_row_addr;
                  phase_in    = row_first_phase;
                  mid_rem_in  = mid_cnt_ff;
               end
            end
         end
      end
   end

   always_comb begin
      res_word              = '0;
      res_word.byte_address = FIELD_ADDR_BITS'(wr_addr_ff);
      res_word.bit_mask     = step_mask;
      res_word.plane_color  = color_ff;
      res_word.xor_op       = invert_ff;
      res_word.last         = final_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_LEFT;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      row_addr_ff   <= row_addr_in;
      wr_addr_ff    <= wr_addr_in;
      rows_rem_ff   <= rows_rem_in;
      mid_rem_ff    <= mid_rem_in;
      mid_cnt_ff    <= mid_cnt_in;
      left_mask_ff  <= left_mask_in;
      right_mask_ff <= right_mask_in;
      color_ff      <= color_in;
      invert_ff     <= invert_in;
   end

endmodule
